// File: rtl/pcsm_pkg.sv
// shared types and constants of the per-channel sliding median filter
package pcsm_pkg;

  // field widths fixed by the interface
  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 10;

  // block sizing
  localparam int CHANNELS = 6;
  localparam int WINDOW   = 5;

  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ranks of the two middle values (equal for an odd window)
  localparam logic [CNT_W-1:0] K_LO = CNT_W'((WINDOW - 1) / 2);
  localparam logic [CNT_W-1:0] K_HI = CNT_W'(WINDOW / 2);

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel_out;
    logic [SAMPLE_W-1:0] filtered;
    logic                is_median;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_RANK,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              take;
    logic              commit;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              rank_en;
    logic [SLOT_W-1:0] rank_slot;
    logic              load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_median;
  } stat_t;

endpackage

// File: rtl/pcsm_dp.sv
// datapath: window store, per-channel counters, rank selection and result register
module pcsm_dp (
  input  logic             clk,
  input  logic             rst,
  input  pcsm_pkg::item_t  item,
  input  pcsm_pkg::cmd_t   cmd,
  output pcsm_pkg::stat_t  stat,
  output pcsm_pkg::result_t result
);
  import pcsm_pkg::*;

  item_t               cur_item;
  logic [CNT_W-1:0]    fill_count [CHANNELS];
  logic [SLOT_W-1:0]   oldest_slot [CHANNELS];
  logic [SAMPLE_W-1:0] store [DEPTH];
  logic [SAMPLE_W-1:0] mem_q;
  logic                rd_pend;
  logic [SLOT_W-1:0]   rd_slot_q;
  logic [SAMPLE_W-1:0] win [WINDOW];
  logic [SAMPLE_W-1:0] med_lo;
  logic [SAMPLE_W-1:0] med_hi;
  logic                med_flag;

  logic                in_range;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [CNT_W-1:0]    cur_fill;
  logic [SLOT_W-1:0]   cur_oldest;
  logic                full;
  logic [SLOT_W-1:0]   wr_slot;
  logic [SLOT_W-1:0]   slot_inc;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] cand;
  logic [CNT_W-1:0]    lt_cnt;
  logic [CNT_W-1:0]    le_cnt;
  logic [SAMPLE_W:0]   mid_sum;

  always_comb begin
    in_range   = 32'(cur_item.channel) < CHANNELS;
    ch_idx     = CH_IDX_W'(cur_item.channel);
    cur_fill   = in_range ? fill_count[ch_idx] : '0;
    cur_oldest = in_range ? oldest_slot[ch_idx] : '0;
    full       = cur_fill == CNT_W'(WINDOW);
    wr_slot    = full ? cur_oldest : cur_fill[SLOT_W-1:0];
    slot_inc   = (cur_oldest == SLOT_W'(WINDOW - 1)) ? '0 : cur_oldest + 1'b1;
    base       = ADDR_W'(32'(ch_idx) * WINDOW);
    wr_addr    = base + ADDR_W'(wr_slot);
    rd_addr    = base + ADDR_W'(cmd.rd_slot);
    stat.need_median = in_range && full;
  end

  // rank of the current candidate against the whole window
  always_comb begin
    cand   = win[cmd.rank_slot];
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < WINDOW; j++) begin
      lt_cnt = lt_cnt + CNT_W'(win[j] < cand);
      le_cnt = le_cnt + CNT_W'(win[j] <= cand);
    end
    mid_sum = {1'b0, med_lo} + {1'b0, med_hi};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        fill_count[c]  <= '0;
        oldest_slot[c] <= '0;
      end
    end else begin
      rd_pend <= cmd.rd_en;
      if (cmd.commit && in_range) begin
        if (full) begin
          oldest_slot[ch_idx] <= slot_inc;
        end else begin
          fill_count[ch_idx]  <= cur_fill + 1'b1;
          oldest_slot[ch_idx] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && in_range) begin
      store[wr_addr] <= cur_item.sample;
    end
    if (cmd.rd_en) begin
      mem_q <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_item <= item;
    end
    if (cmd.commit) begin
      med_flag <= stat.need_median;
    end
    rd_slot_q <= cmd.rd_slot;
    if (rd_pend) begin
      win[rd_slot_q] <= mem_q;
    end
    if (cmd.rank_en) begin
      if (lt_cnt <= K_LO && le_cnt > K_LO) begin
        med_lo <= cand;
      end
      if (lt_cnt <= K_HI && le_cnt > K_HI) begin
        med_hi <= cand;
      end
    end
    if (cmd.load_out) begin
      result.channel_out <= cur_item.channel;
      result.filtered    <= med_flag ? mid_sum[SAMPLE_W:1] : cur_item.sample;
      result.is_median   <= med_flag;
    end
  end

endmodule

// File: rtl/pcsm_ctrl.sv
// controller: sequences write, window read-out, rank scan and result hand-off
module pcsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  output logic            result_valid,
  input  logic            result_stall,
  input  pcsm_pkg::stat_t stat,
  output pcsm_pkg::cmd_t  cmd
);
  import pcsm_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.rd_slot   = cnt[SLOT_W-1:0];
    cmd.rank_slot = cnt[SLOT_W-1:0];
    item_stall    = state != ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.commit = 1'b1;
        cnt_next   = '0;
        state_next = stat.need_median ? ST_READ : ST_FINISH;
      end
      ST_READ: begin
        // the pass with cnt at WINDOW issues no read and lets the last registered read land
        cmd.rd_en = cnt != CNT_W'(WINDOW);
        if (cnt == CNT_W'(WINDOW)) begin
          cnt_next   = '0;
          state_next = ST_RANK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_RANK: begin
        cmd.rank_en = 1'b1;
        if (cnt == CNT_W'(WINDOW - 1)) begin
          cnt_next   = '0;
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/per_channel_sliding_median_core.sv
// top level of the per-channel sliding median filter
//
//   channel   direction  beat payload             handshake
//   item      in         channel, sample          item_valid / item_stall
//   result    out        channel_out, filtered,   result_valid / result_stall
//                        is_median
//
// one item at a time; item_stall is low only while the controller is idle
// passthrough beat (window filling or unknown channel): after the write state the
//   finish state loads the result register, and the controller returns to idle to
//   take the next item
// median beat: the result is loaded after the read state has read the channel's
//   window out of the store one entry a cycle, plus a closing pass with no read that
//   lets the last read land, and the rank state has ranked one candidate a cycle
// rst is synchronous; it empties every channel's window and drops result_valid
// a stalled result holds in its register; the next item may be accepted and
//   worked on meanwhile, and only its hand-off waits for the register to free
module per_channel_sliding_median_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pcsm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output pcsm_pkg::result_t result
);
  import pcsm_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: write, window read-out, rank scan, hand-off
  pcsm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // window store, per-channel fill and oldest-slot counters, rank unit
  pcsm_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule
